### sv/iso_timestamp_to_epoch_seconds_defines.svh
// ----------------------------------------------------------------------------
// Timestamp converter assertion macros
// Concurrent check wrappers on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef ISO_TIMESTAMP_TO_EPOCH_SECONDS_DEFINES_SVH
`define ISO_TIMESTAMP_TO_EPOCH_SECONDS_DEFINES_SVH

// same-cycle implication
`define ITSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("itse: same-cycle check failed");

// next-cycle implication
`define ITSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("itse: next-cycle check failed");

`endif

### sv/itse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp converter package
// Types, constants and the conversion micro-program shared by the block.
// ----------------------------------------------------------------------------
package itse_pkg;

	localparam int YearW  = 14;
	localparam int FieldW = 7;
	localparam int SecW   = 39;
	localparam int MulAW  = 22;
	localparam int MulBW  = 17;
	localparam int StepW  = 4;

	localparam logic [StepW-1:0]  LastStep     = 4'd11;
	localparam logic [YearW-1:0]  YearMin      = 14'd1970;
	localparam logic [YearW-1:0]  YearMax      = 14'd9999;
	localparam logic [FieldW-1:0] OffHourMax   = 7'd14;
	localparam logic [SecW-1:0]   DaysToEpoch  = 39'd719468;
	localparam logic [MulBW-1:0]  SecPerDay    = 17'd86400;
	localparam logic [MulBW-1:0]  SecPerHour   = 17'd3600;
	localparam logic [MulBW-1:0]  SecPerMin    = 17'd60;
	localparam logic [MulBW-1:0]  DaysPerYear  = 17'd365;
	localparam logic [MulBW-1:0]  RecipHundred = 17'd5243;
	localparam logic [MulBW-1:0]  Unity        = 17'd1;

	typedef enum logic [2:0] {
		PH_DATETIME    = 3'd0,
		PH_AFTER_SEC   = 3'd1,
		PH_FRAC_FIRST  = 3'd2,
		PH_FRAC        = 3'd3,
		PH_ZULU        = 3'd4,
		PH_OFFSET      = 3'd5,
		PH_OFFSET_DONE = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_CHECK,
		CV_RUN,
		CV_DONE
	} conv_state_t;

	typedef enum logic [2:0] {
		MOP_LOAD,
		MOP_ADD,
		MOP_SUB,
		MOP_QUOT,
		MOP_OFFS
	} mop_t;

	typedef enum logic [3:0] {
		AS_YEAR,
		AS_YEAR4,
		AS_QUOT,
		AS_DAYS,
		AS_HOUR,
		AS_MIN,
		AS_SEC,
		AS_OFFH,
		AS_OFFM
	} asel_t;

	typedef struct packed {
		asel_t              asel;
		logic [MulBW-1:0]   b;
		mop_t               op;
	} uop_t;

	typedef struct packed {
		logic               layout_ok;
		logic [YearW-1:0]   year;
		logic [FieldW-1:0]  cent;
		logic [FieldW-1:0]  yy;
		logic [FieldW-1:0]  month;
		logic [FieldW-1:0]  day;
		logic [FieldW-1:0]  hour;
		logic [FieldW-1:0]  minute;
		logic [FieldW-1:0]  second;
		logic               off_neg;
		logic [FieldW-1:0]  off_hour;
		logic [FieldW-1:0]  off_min;
	} fields_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic               ok;
		logic [SecW-1:0]    seconds;
	} conv_res_t;

	// days = 365y + y/4 - y/100 + y/400 + doy - 719468, then seconds
	function automatic uop_t uop_of(logic [StepW-1:0] step);
		uop_t u;
		u = '{asel: AS_YEAR, b: Unity, op: MOP_ADD};
		unique case (step)
			4'd0:  u = '{asel: AS_YEAR,  b: DaysPerYear,  op: MOP_ADD};
			4'd1:  u = '{asel: AS_YEAR4, b: Unity,        op: MOP_ADD};
			4'd2:  u = '{asel: AS_YEAR,  b: RecipHundred, op: MOP_QUOT};
			4'd3:  u = '{asel: AS_QUOT,  b: Unity,        op: MOP_SUB};
			4'd4:  u = '{asel: AS_YEAR4, b: RecipHundred, op: MOP_QUOT};
			4'd5:  u = '{asel: AS_QUOT,  b: Unity,        op: MOP_ADD};
			4'd6:  u = '{asel: AS_DAYS,  b: SecPerDay,    op: MOP_LOAD};
			4'd7:  u = '{asel: AS_HOUR,  b: SecPerHour,   op: MOP_ADD};
			4'd8:  u = '{asel: AS_MIN,   b: SecPerMin,    op: MOP_ADD};
			4'd9:  u = '{asel: AS_SEC,   b: Unity,        op: MOP_ADD};
			4'd10: u = '{asel: AS_OFFH,  b: SecPerHour,   op: MOP_OFFS};
			4'd11: u = '{asel: AS_OFFM,  b: SecPerMin,    op: MOP_OFFS};
			default: u = '{asel: AS_YEAR, b: Unity, op: MOP_ADD};
		endcase
		return u;
	endfunction

	// days from March 1 to the first of the shifted month
	function automatic logic [8:0] doy_base(logic [3:0] mp);
		logic [8:0] d;
		d = 9'd0;
		case (mp)
			4'd0:  d = 9'd0;
			4'd1:  d = 9'd31;
			4'd2:  d = 9'd61;
			4'd3:  d = 9'd92;
			4'd4:  d = 9'd122;
			4'd5:  d = 9'd153;
			4'd6:  d = 9'd184;
			4'd7:  d = 9'd214;
			4'd8:  d = 9'd245;
			4'd9:  d = 9'd275;
			4'd10: d = 9'd306;
			4'd11: d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### sv/iso_timestamp_to_epoch_seconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp to epoch seconds converter
// Parses a character stream timestamp and returns UTC seconds after the last beat.
// ----------------------------------------------------------------------------
// A non-final character beat updates the parser and gives no result.
// Final beat: the fields are checked; a failed check goes straight to the
// output register, a valid one first runs 12 multiply-accumulate steps and
// done. Throughput: one character per cycle while s_tready is high; after the
// final beat the input stays off until the result beat is taken.
// Reset: arst_n clears parser, sequencer and output valid at once.
// ----------------------------------------------------------------------------
`include "iso_timestamp_to_epoch_seconds_defines.svh"

module iso_timestamp_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [0] valid_res, [39:1] utc_seconds
);
	import itse_pkg::*;

	fields_t     fields;
	conv_res_t   res;
	logic        beat;
	logic        out_valid_q;
	logic [39:0] out_data_q;

	assign s_tready = !res.busy && !out_valid_q;
	assign beat     = s_tvalid && s_tready;

	itse_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat),
		.ch     (s_tdata),
		.last   (s_tlast),
		.fields (fields)
	);

	itse_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (beat && s_tlast),
		.fields (fields),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) out_data_q <= {res.seconds, res.ok};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ITSE_ASSERT_NEXT(a_last_starts_conv, s_tvalid && s_tready && s_tlast, res.busy)
	`ITSE_ASSERT_NOW(a_done_no_overwrite, res.done, !out_valid_q)
	`ITSE_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tdata[0], m_tdata[39:1] == 39'd0)

endmodule

### sv/itse_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp character parser
// Checks the fixed layout one character per beat and gathers the fields.
// ----------------------------------------------------------------------------
module itse_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             beat,
	input  logic [7:0]       ch,
	input  logic             last,
	output itse_pkg::fields_t fields
);
	import itse_pkg::*;

	localparam logic [7:0] ChDash  = 8'h2d;
	localparam logic [7:0] ChT     = 8'h54;
	localparam logic [7:0] ChColon = 8'h3a;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChZ     = 8'h5a;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	function automatic logic [FieldW-1:0] acc7(logic [FieldW-1:0] a, logic [3:0] d);
		logic [10:0] t;
		t = (11'(a) << 3) + (11'(a) << 1) + 11'(d);
		return t[FieldW-1:0];
	endfunction

	function automatic logic [YearW-1:0] acc14(logic [YearW-1:0] a, logic [3:0] d);
		logic [17:0] t;
		t = (18'(a) << 3) + (18'(a) << 1) + 18'(d);
		return t[YearW-1:0];
	endfunction

	phase_t             phase_q, phase_d;
	logic [4:0]         pos_q, pos_d;
	logic               err_q, err_d;
	logic [YearW-1:0]   year_q, year_d;
	logic [FieldW-1:0]  cent_q, cent_d, yy_q, yy_d;
	logic [FieldW-1:0]  month_q, month_d, day_q, day_d;
	logic [FieldW-1:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
	logic               neg_q, neg_d;
	logic [FieldW-1:0]  offh_q, offh_d, offm_q, offm_d;
	logic               is_dig;
	logic               sfx;
	logic [3:0]         dig;

	assign is_dig = (ch >= ChZero) && (ch <= ChNine);
	assign dig    = ch[3:0];

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		err_d    = err_q;
		year_d   = year_q;
		cent_d   = cent_q;
		yy_d     = yy_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		neg_d    = neg_q;
		offh_d   = offh_q;
		offm_d   = offm_q;
		sfx      = 1'b0;
		if (!err_q) begin
			unique case (phase_q)
				PH_DATETIME: begin
					if (pos_q == 5'd4 || pos_q == 5'd7) begin
						if (ch != ChDash) err_d = 1'b1;
					end else if (pos_q == 5'd10) begin
						if (ch != ChT) err_d = 1'b1;
					end else if (pos_q == 5'd13 || pos_q == 5'd16) begin
						if (ch != ChColon) err_d = 1'b1;
					end else if (!is_dig) begin
						err_d = 1'b1;
					end else if (pos_q <= 5'd3) begin
						year_d = acc14(year_q, dig);
						if (pos_q <= 5'd1) cent_d = acc7(cent_q, dig);
						else yy_d = acc7(yy_q, dig);
					end else if (pos_q <= 5'd6) begin
						month_d = acc7(month_q, dig);
					end else if (pos_q <= 5'd9) begin
						day_d = acc7(day_q, dig);
					end else if (pos_q <= 5'd12) begin
						hour_d = acc7(hour_q, dig);
					end else if (pos_q <= 5'd15) begin
						minute_d = acc7(minute_q, dig);
					end else begin
						second_d = acc7(second_q, dig);
					end
					if (pos_q >= 5'd18) begin
						phase_d = PH_AFTER_SEC;
						pos_d   = 5'd0;
					end else begin
						pos_d = pos_q + 5'd1;
					end
				end
				PH_AFTER_SEC: begin
					if (ch == ChDot) phase_d = PH_FRAC_FIRST;
					else sfx = 1'b1;
				end
				PH_FRAC_FIRST: begin
					if (is_dig) phase_d = PH_FRAC;
					else err_d = 1'b1;
				end
				PH_FRAC: begin
					if (!is_dig) sfx = 1'b1;
				end
				PH_OFFSET: begin
					if (pos_q == 5'd2) begin
						if (ch != ChColon) err_d = 1'b1;
					end else if (!is_dig) begin
						err_d = 1'b1;
					end else if (pos_q <= 5'd1) begin
						offh_d = acc7(offh_q, dig);
					end else begin
						offm_d = acc7(offm_q, dig);
					end
					if (pos_q >= 5'd4) begin
						phase_d = PH_OFFSET_DONE;
						pos_d   = 5'd0;
					end else begin
						pos_d = pos_q + 5'd1;
					end
				end
				default: err_d = 1'b1;
			endcase
		end
		if (sfx) begin
			if (ch == ChZ) begin
				phase_d = PH_ZULU;
			end else if (ch == ChPlus || ch == ChDash) begin
				neg_d   = (ch == ChDash);
				phase_d = PH_OFFSET;
				pos_d   = 5'd0;
			end else begin
				err_d = 1'b1;
			end
		end
	end

	always_comb begin
		fields.layout_ok = !err_d && (phase_d == PH_ZULU || phase_d == PH_OFFSET_DONE);
		fields.year      = year_d;
		fields.cent      = cent_d;
		fields.yy        = yy_d;
		fields.month     = month_d;
		fields.day       = day_d;
		fields.hour      = hour_d;
		fields.minute    = minute_d;
		fields.second    = second_d;
		fields.off_neg   = neg_d;
		fields.off_hour  = offh_d;
		fields.off_min   = offm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DATETIME;
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			cent_q   <= '0;
			yy_q     <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			neg_q    <= 1'b0;
			offh_q   <= '0;
			offm_q   <= '0;
		end else if (beat) begin
			if (last) begin
				phase_q  <= PH_DATETIME;
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				cent_q   <= '0;
				yy_q     <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
				neg_q    <= 1'b0;
				offh_q   <= '0;
				offm_q   <= '0;
			end else begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				err_q    <= err_d;
				year_q   <= year_d;
				cent_q   <= cent_d;
				yy_q     <= yy_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				neg_q    <= neg_d;
				offh_q   <= offh_d;
				offm_q   <= offm_d;
			end
		end
	end

endmodule

### sv/itse_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp range check and epoch conversion
// Validates the gathered fields, then if valid runs a short micro-program
// on one shared multiply-accumulate unit to form the epoch seconds.
// ----------------------------------------------------------------------------
module itse_conv (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  itse_pkg::fields_t  fields,
	output itse_pkg::conv_res_t res
);
	import itse_pkg::*;

	conv_state_t        state_q, state_d;
	fields_t            fld_q;
	logic [YearW-1:0]   y_q;
	logic [SecW-1:0]    acc_q;
	logic [FieldW-1:0]  quot_q;
	logic [StepW-1:0]   step_q;

	logic               leap, ok;
	logic [4:0]         mlen;
	logic               early;
	logic [3:0]         mp;
	logic [SecW-1:0]    init;
	uop_t               u;
	logic [MulAW-1:0]   a_op;
	logic [SecW-1:0]    prod;
	logic               ld_fld, ld_init, do_step;

	always_comb begin
		leap = (fld_q.yy == '0) ? (fld_q.cent[1:0] == 2'd0) : (fld_q.yy[1:0] == 2'd0);
		case (fld_q.month) inside
			7'd2:                     mlen = leap ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:  mlen = 5'd30;
			default:                  mlen = 5'd31;
		endcase
		ok = fld_q.layout_ok
			&& fld_q.year >= YearMin && fld_q.year <= YearMax
			&& fld_q.month >= 7'd1 && fld_q.month <= 7'd12
			&& fld_q.day >= 7'd1 && fld_q.day <= 7'(mlen)
			&& fld_q.hour <= 7'd23 && fld_q.minute <= 7'd59 && fld_q.second <= 7'd59
			&& fld_q.off_hour <= OffHourMax && fld_q.off_min <= 7'd59
			&& !(fld_q.off_hour == OffHourMax && fld_q.off_min != '0);
		early = fld_q.month <= 7'd2;
		mp    = early ? 4'(fld_q.month + 7'd9) : 4'(fld_q.month - 7'd3);
		init  = 39'(doy_base(mp)) + 39'(fld_q.day) - 39'd1 - DaysToEpoch;
	end

	always_comb begin
		u = uop_of(step_q);
		case (u.asel)
			AS_YEAR:  a_op = 22'(y_q);
			AS_YEAR4: a_op = 22'(y_q[YearW-1:2]);
			AS_QUOT:  a_op = 22'(quot_q);
			AS_DAYS:  a_op = acc_q[MulAW-1:0];
			AS_HOUR:  a_op = 22'(fld_q.hour);
			AS_MIN:   a_op = 22'(fld_q.minute);
			AS_SEC:   a_op = 22'(fld_q.second);
			AS_OFFH:  a_op = 22'(fld_q.off_hour);
			AS_OFFM:  a_op = 22'(fld_q.off_min);
			default:  a_op = '0;
		endcase
		prod = 39'(a_op) * 39'(u.b);
	end

	always_comb begin
		state_d     = state_q;
		ld_fld      = 1'b0;
		ld_init     = 1'b0;
		do_step     = 1'b0;
		res.busy    = (state_q != CV_IDLE);
		res.done    = 1'b0;
		res.ok      = 1'b0;
		res.seconds = '0;
		unique case (state_q)
			CV_IDLE: begin
				if (start) begin
					ld_fld  = 1'b1;
					state_d = CV_CHECK;
				end
			end
			CV_CHECK: begin
				if (ok) begin
					ld_init = 1'b1;
					state_d = CV_RUN;
				end else begin
					res.done = 1'b1;
					state_d  = CV_IDLE;
				end
			end
			CV_RUN: begin
				do_step = 1'b1;
				if (step_q == LastStep) state_d = CV_DONE;
			end
			CV_DONE: begin
				res.done    = 1'b1;
				res.ok      = 1'b1;
				res.seconds = acc_q;
				state_d     = CV_IDLE;
			end
			default: state_d = CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ld_init) step_q <= '0;
			else if (do_step) step_q <= step_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_fld) fld_q <= fields;
		if (ld_init) begin
			y_q   <= fld_q.year - (early ? 14'd1 : 14'd0);
			acc_q <= init;
		end else if (do_step) begin
			case (u.op)
				MOP_LOAD: acc_q  <= prod;
				MOP_ADD:  acc_q  <= acc_q + prod;
				MOP_SUB:  acc_q  <= acc_q - prod;
				MOP_QUOT: quot_q <= prod[25:19];
				MOP_OFFS: acc_q  <= fld_q.off_neg ? acc_q + prod : acc_q - prod;
				default:  acc_q  <= acc_q;
			endcase
		end
	end

endmodule

### tb/iso_timestamp_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp converter testbench
// Streams timestamp strings one character per beat: a directed table of
// boundary dates, offsets, layout and range errors, then random strings,
// mostly well-formed with random fields and some corrupted or pure noise.
// Both sides insert random gaps. Each result beat is checked against a pinned
// table value or a behavioral parser and day-count model in the bench.
// ----------------------------------------------------------------------------
module iso_timestamp_to_epoch_seconds_tb;
	import itse_pkg::*;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam int RAND_BEATS   = 970;
	localparam int MAX_SHOWN    = 10;
	localparam int DRAIN_CYCLES = 32;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_BAD,
		EXP_GOOD
	} pin_t;

	typedef struct packed {
		logic            ok;
		logic [SecW-1:0] secs;
	} stamp_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	iso_timestamp_to_epoch_seconds DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	logic [4:0]        st_pos;
	phase_t            st_phase;
	logic [YearW-1:0]  st_year;
	logic [FieldW-1:0] st_month, st_day, st_hour, st_min, st_sec;
	logic              st_off_neg;
	logic [FieldW-1:0] st_offh, st_offm;
	logic              st_err;

	stamp_t     pending_stamps[$];
	int         err_cnt = 0;
	bit         pin_on  = 1'b0;
	stamp_t     pin_val;
	logic [7:0] text_q[$];
	string      dir_text[$];
	pin_t       dir_pin[$];
	longint     dir_secs[$];
	int         tx_run = 0, rx_run = 0;
	bit         tx_calm, rx_calm;

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		#1000000;
		$display("** iso_timestamp_to_epoch_seconds: FAILED **");
		$finish;
	end

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic int shift_in(int acc, logic [7:0] c);
		return acc * 10 + int'(c) - int'(CH_ZERO);
	endfunction

	function automatic int month_days(int y, int m);
		bit leap;
		leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		if (m == 2)
			return leap ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic void clear_parse();
		st_pos     = '0;
		st_phase   = PH_DATETIME;
		st_year    = '0;
		st_month   = '0;
		st_day     = '0;
		st_hour    = '0;
		st_min     = '0;
		st_sec     = '0;
		st_off_neg = 1'b0;
		st_offh    = '0;
		st_offm    = '0;
		st_err     = 1'b0;
	endfunction

	function automatic void take_suffix(logic [7:0] c);
		if (c == CH_Z) begin
			st_phase = PH_ZULU;
		end else if (c == CH_PLUS || c == CH_DASH) begin
			st_off_neg = (c == CH_DASH);
			st_phase   = PH_OFFSET;
			st_pos     = '0;
		end else begin
			st_err = 1'b1;
		end
	endfunction

	function automatic void parse_char(logic [7:0] c);
		logic [4:0] p;
		p = st_pos;
		if (st_err)
			return;
		case (st_phase)
			PH_DATETIME: begin
				if (p == 4 || p == 7) begin
					if (c != CH_DASH) st_err = 1'b1;
				end else if (p == 10) begin
					if (c != CH_T) st_err = 1'b1;
				end else if (p == 13 || p == 16) begin
					if (c != CH_COLON) st_err = 1'b1;
				end else if (!is_digit(c)) begin
					st_err = 1'b1;
				end else if (p <= 3) begin
					st_year = YearW'(shift_in(st_year, c));
				end else if (p <= 6) begin
					st_month = FieldW'(shift_in(st_month, c));
				end else if (p <= 9) begin
					st_day = FieldW'(shift_in(st_day, c));
				end else if (p <= 12) begin
					st_hour = FieldW'(shift_in(st_hour, c));
				end else if (p <= 15) begin
					st_min = FieldW'(shift_in(st_min, c));
				end else begin
					st_sec = FieldW'(shift_in(st_sec, c));
				end
				if (p >= 18) begin
					st_phase = PH_AFTER_SEC;
					st_pos   = '0;
				end else begin
					st_pos = p + 5'd1;
				end
			end
			PH_AFTER_SEC: begin
				if (c == CH_DOT)
					st_phase = PH_FRAC_FIRST;
				else
					take_suffix(c);
			end
			PH_FRAC_FIRST: begin
				if (is_digit(c))
					st_phase = PH_FRAC;
				else
					st_err = 1'b1;
			end
			PH_FRAC: begin
				if (!is_digit(c))
					take_suffix(c);
			end
			PH_OFFSET: begin
				if (p == 2) begin
					if (c != CH_COLON) st_err = 1'b1;
				end else if (!is_digit(c)) begin
					st_err = 1'b1;
				end else if (p <= 1) begin
					st_offh = FieldW'(shift_in(st_offh, c));
				end else begin
					st_offm = FieldW'(shift_in(st_offm, c));
				end
				if (p >= 4) begin
					st_phase = PH_OFFSET_DONE;
					st_pos   = '0;
				end else begin
					st_pos = p + 5'd1;
				end
			end
			default: st_err = 1'b1;
		endcase
	endfunction

	function automatic stamp_t stamp_result();
		stamp_t r;
		logic   good;
		longint y, era, yoe, mp, doy, doe, secs, off;
		r = '0;
		good = !st_err && (st_phase == PH_ZULU || st_phase == PH_OFFSET_DONE)
			&& st_year >= 1970 && st_year <= 9999 && st_month >= 1 && st_month <= 12
			&& st_day >= 1 && int'(st_day) <= month_days(st_year, st_month)
			&& st_hour <= 23 && st_min <= 59 && st_sec <= 59;
		if (good && st_phase == PH_OFFSET_DONE)
			good = st_offh <= 14 && st_offm <= 59 && !(st_offh == 14 && st_offm != 0);
		if (!good)
			return r;
		y    = longint'(st_year) - ((st_month <= 2) ? 1 : 0);
		era  = y / 400;
		yoe  = y - era * 400;
		mp   = (st_month > 2) ? longint'(st_month) - 3 : longint'(st_month) + 9;
		doy  = (153 * mp + 2) / 5 + longint'(st_day) - 1;
		doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		secs = (era * 146097 + doe - 719468) * 86400 + longint'(st_hour) * 3600
			+ longint'(st_min) * 60 + longint'(st_sec);
		if (st_phase == PH_OFFSET_DONE) begin
			off  = longint'(st_offh) * 3600 + longint'(st_offm) * 60;
			secs = st_off_neg ? secs + off : secs - off;
		end
		r.ok   = 1'b1;
		r.secs = SecW'(secs);
		return r;
	endfunction

	function automatic int draw_gap(inout int run, inout bit calm);
		if (run == 0) begin
			run  = $urandom_range(1, 24);
			calm = ($urandom_range(0, 3) == 0);
		end
		run--;
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	function automatic int pick_field(int top);
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return $urandom_range(0, 99);
		if (r == 1)
			return $urandom_range(top, top + 1);
		return $urandom_range(0, top);
	endfunction

	function automatic void put_num(int v, int digits);
		int scale;
		scale = 1;
		repeat (digits - 1) scale = scale * 10;
		repeat (digits) begin
			text_q.push_back(CH_ZERO + 8'((v / scale) % 10));
			scale = scale / 10;
		end
	endfunction

	function automatic void row(string t, pin_t p, longint s);
		dir_text.push_back(t);
		dir_pin.push_back(p);
		dir_secs.push_back(s);
	endfunction

	// enter and leave at a falling edge
	task automatic push_beat(logic [7:0] c, logic fin);
		int     gap;
		stamp_t r;
		gap = draw_gap(tx_run, tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= fin;
		do @(posedge clk); while (s_tready !== 1'b1);
		parse_char(c);
		if (fin) begin
			r = stamp_result();
			if (pin_on)
				r = pin_val;
			pin_on = 1'b0;
			pending_stamps.push_back(r);
			clear_parse();
		end
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending_stamps.size() > 0);
	endtask

	initial begin : drain_results
		int              gap;
		stamp_t          want;
		logic            got_ok;
		logic [SecW-1:0] got_secs;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(rx_run, rx_calm);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got_ok   = m_tdata[0];
			got_secs = m_tdata[SecW:1];
			if (pending_stamps.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_SHOWN)
					$display("unexpected result beat: ok=%0b secs=%0d", got_ok,
						$signed(got_secs));
			end else begin
				want = pending_stamps.pop_front();
				if (want.ok !== got_ok || want.secs !== got_secs) begin
					err_cnt++;
					if (err_cnt <= MAX_SHOWN)
						$display("mismatch: ok exp %0b got %0b, secs exp %0d got %0d",
							want.ok, got_ok, $signed(want.secs), $signed(got_secs));
				end
			end
			@(negedge clk);
		end
	end

	initial begin : stimulus
		string line;
		int    sent, nstr, kind, r, n, yr, mo, dy;
		clear_parse();
		row("1970-01-01T00:00:00Z",            EXP_GOOD,  0);
		row("9999-12-31T23:59:59Z",            EXP_GOOD,  64'sd253402300799);
		row("1970-01-01T00:00:00+14:00",       EXP_GOOD,  -64'sd50400);
		row("9999-12-31T23:59:59-14:00",       EXP_GOOD,  64'sd253402351199);
		row("2000-02-29T12:34:56.789Z",        EXP_MODEL, 0);
		row("2024-02-29T08:15:00.0-05:30",     EXP_MODEL, 0);
		row("2400-02-29T23:59:59+00:00",       EXP_MODEL, 0);
		row("2100-02-29T00:00:00Z",            EXP_BAD,   0);
		row("1969-12-31T23:59:59Z",            EXP_BAD,   0);
		row("2023-13-01T00:00:00Z",            EXP_BAD,   0);
		row("2023-00-10T00:00:00Z",            EXP_BAD,   0);
		row("2023-04-31T00:00:00Z",            EXP_BAD,   0);
		row("2023-06-00T00:00:00Z",            EXP_BAD,   0);
		row("2023-06-15T24:00:00Z",            EXP_BAD,   0);
		row("2023-06-15T12:60:00Z",            EXP_BAD,   0);
		row("2016-12-31T23:59:60Z",            EXP_BAD,   0);
		row("2023-06-15T12:00:00+15:00",       EXP_BAD,   0);
		row("2023-06-15T12:00:00+14:30",       EXP_BAD,   0);
		row("2023-06-15T12:00:00-09:60",       EXP_BAD,   0);
		row("2023/06-15T12:00:00Z",            EXP_BAD,   0);
		row("2023-06-15T12:00:00ZZ",           EXP_BAD,   0);
		row("2023-06-15T12:00:00+01:00:",      EXP_BAD,   0);
		row("2023-06-15T12:00:00",             EXP_BAD,   0);
		row("2023-06-15T12:00:00.Z",           EXP_BAD,   0);
		row("Z",                               EXP_BAD,   0);

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int k = 0; k < dir_text.size(); k++) begin
			line        = dir_text[k];
			pin_on      = (dir_pin[k] != EXP_MODEL);
			pin_val.ok  = (dir_pin[k] == EXP_GOOD);
			pin_val.secs = (dir_pin[k] == EXP_GOOD) ? SecW'(dir_secs[k]) : '0;
			for (int i = 0; i < line.len(); i++)
				push_beat(line[i], i == line.len() - 1);
		end
		hold_until_drained();

		sent = 0;
		nstr = 0;
		while (sent < RAND_BEATS) begin
			text_q.delete();
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				n = $urandom_range(1, 30);
				repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				r = $urandom_range(0, 9);
				case (r)
					0:       yr = $urandom_range(0, 9999);
					1:       yr = 1970;
					2:       yr = 9999;
					3:       yr = 2000;
					4:       yr = 2100;
					5:       yr = 2400;
					default: yr = $urandom_range(1970, 2500);
				endcase
				mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
				r = $urandom_range(0, 9);
				if (r == 0)
					dy = $urandom_range(0, 99);
				else if (r < 3)
					dy = $urandom_range(28, 31);
				else
					dy = $urandom_range(1, month_days(yr, mo));
				if ($urandom_range(0, 15) == 0) begin
					mo = 2;
					dy = $urandom_range(28, 29);
				end
				put_num(yr, 4);
				text_q.push_back(CH_DASH);
				put_num(mo, 2);
				text_q.push_back(CH_DASH);
				put_num(dy, 2);
				text_q.push_back(CH_T);
				put_num(pick_field(23), 2);
				text_q.push_back(CH_COLON);
				put_num(pick_field(59), 2);
				text_q.push_back(CH_COLON);
				put_num(pick_field(59), 2);
				if ($urandom_range(0, 1) == 1) begin
					text_q.push_back(CH_DOT);
					n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
					repeat (n) put_num($urandom_range(0, 9), 1);
				end
				if ($urandom_range(0, 2) == 0) begin
					text_q.push_back(CH_Z);
				end else begin
					text_q.push_back($urandom_range(0, 1) ? CH_DASH : CH_PLUS);
					r = $urandom_range(0, 7);
					if (r == 0)
						put_num($urandom_range(0, 99), 2);
					else if (r == 1)
						put_num($urandom_range(14, 15), 2);
					else
						put_num($urandom_range(0, 14), 2);
					text_q.push_back(CH_COLON);
					put_num(pick_field(59), 2);
				end
				// damage some well-formed strings
				if (kind == 1) begin
					case ($urandom_range(0, 2))
						0: text_q[$urandom_range(0, text_q.size() - 1)] =
							8'($urandom_range(0, 255));
						1: begin
							n = $urandom_range(1, text_q.size() - 1);
							while (text_q.size() > n) void'(text_q.pop_back());
						end
						default: begin
							n = $urandom_range(1, 3);
							repeat (n) text_q.push_back(($urandom_range(0, 1) == 1) ?
								CH_Z : 8'($urandom_range(0, 255)));
						end
					endcase
				end
			end
			foreach (text_q[i])
				push_beat(text_q[i], i == text_q.size() - 1);
			sent += text_q.size();
			nstr++;
			if (nstr % 16 == 15)
				hold_until_drained();
		end
		s_tvalid <= 1'b0;

		while (pending_stamps.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("** iso_timestamp_to_epoch_seconds: PASSED **");
		else
			$display("** iso_timestamp_to_epoch_seconds: FAILED **");
		$finish;
	end

endmodule
